// File: design/mclp_pkg.sv
`timescale 1ns / 1ps
package mclp_pkg;

	localparam int MAX_LINE_DEF = 1024;

	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_ADDR_W-1:0] REG_MAX_READ_COUNT = CFG_ADDR_W'(0);
	localparam logic [15:0] MAX_READ_COUNT_RST = 16'd1024;

	typedef enum logic [2:0] {
		CMD_OTHER = 3'd0,
		CMD_R     = 3'd1,
		CMD_T     = 3'd2,
		CMD_W     = 3'd3,
		CMD_X     = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_BAD  = 2'd1,
		ST_OVER = 2'd2,
		ST_ODD  = 2'd3
	} status_t;

	typedef struct packed {
		logic        kind;
		cmd_t        command;
		logic [7:0]  letter;
		status_t     status;
		logic [63:0] address;
		logic [31:0] count;
		logic [7:0]  data_byte;
		logic [9:0]  byte_index;
	} result_t;

endpackage

// File: design/mclp_if.sv
`timescale 1ns / 1ps
interface mclp_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;

	modport source (output valid, output ch, input ready);
	modport sink (input valid, input ch, output ready);
endinterface

interface mclp_result_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [2:0]  command;
	logic [7:0]  letter;
	logic [1:0]  status;
	logic [63:0] address;
	logic [31:0] count;
	logic [7:0]  data_byte;
	logic [9:0]  byte_index;

	modport source (
		output valid, output kind, output command, output letter, output status,
		output address, output count, output data_byte, output byte_index,
		input ready
	);
	modport sink (
		input valid, input kind, input command, input letter, input status,
		input address, input count, input data_byte, input byte_index,
		output ready
	);
endinterface

// File: design/mclp_cfg.sv
`timescale 1ns / 1ps
module mclp_cfg import mclp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	output logic [15:0]           max_read_count
);

	logic [15:0] max_read_count_q;
	logic        hit;

	// word decode: byte offset bits are ignored
	assign hit = (paddr[CFG_ADDR_W-1:2] == REG_MAX_READ_COUNT[CFG_ADDR_W-1:2]);
	assign pready = 1'b1;
	assign max_read_count = max_read_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_read_count_q <= MAX_READ_COUNT_RST;
		end else if (psel && penable && pwrite && hit) begin
			max_read_count_q <= pwdata[15:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (hit) begin
			prdata = {{(CFG_DATA_W-16){1'b0}}, max_read_count_q};
		end
	end

endmodule

// File: design/mclp_parser.sv
`timescale 1ns / 1ps
module mclp_parser import mclp_pkg::*; #(
	parameter int MAX_LINE = MAX_LINE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  ch,
	input  logic [15:0] max_read_count,
	output logic        produce,
	output result_t     res
);

	localparam int POS_W = $clog2(MAX_LINE + 1);

	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_NUL   = 8'd0;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef enum logic [1:0] {
		PH_ADDR,
		PH_COUNT,
		PH_DATA,
		PH_DONE
	} phase_t;

	logic [POS_W-1:0] pos_q, pos_d;
	cmd_t             cmd_q, cmd_d;
	logic [7:0]       letter_q, letter_d;
	phase_t           phase_q, phase_d;
	logic [63:0]      addr_q, addr_d;
	logic [31:0]      count_q, count_d;
	logic [3:0]       nibble_q, nibble_d;
	logic             half_q, half_d;
	logic [9:0]       bytes_q, bytes_d;
	logic             err_q, err_d;

	logic             hex_ok;
	logic [3:0]       hex_val;
	logic             dec_ok;
	logic             line_end;
	cmd_t             v_cmd;
	status_t          v_status;

	always_comb begin
		hex_ok  = 1'b1;
		hex_val = 4'd0;
		if (ch inside {["0":"9"]}) begin
			hex_val = 4'(ch - 8'h30);
		end else if (ch inside {["a":"f"]}) begin
			hex_val = 4'(ch - 8'h57);
		end else if (ch inside {["A":"F"]}) begin
			hex_val = 4'(ch - 8'h37);
		end else begin
			hex_ok = 1'b0;
		end
		dec_ok = ch inside {["0":"9"]};
	end

	assign line_end = (ch == CH_CR) || (ch == CH_NUL) || (pos_q >= POS_W'(MAX_LINE));

	always_comb begin
		pos_d    = pos_q;
		cmd_d    = cmd_q;
		letter_d = letter_q;
		phase_d  = phase_q;
		addr_d   = addr_q;
		count_d  = count_q;
		nibble_d = nibble_q;
		half_d   = half_q;
		bytes_d  = bytes_q;
		err_d    = err_q;
		produce  = 1'b0;
		v_cmd    = CMD_OTHER;
		v_status = ST_OK;
		res      = '0;

		if (line_end) begin
			produce = 1'b1;
			v_cmd = (pos_q == '0) ? CMD_OTHER : cmd_q;
			res.kind = 1'b1;
			res.command = v_cmd;
			res.letter = (pos_q == '0) ? ch : letter_q;
			res.address = addr_q;
			case (v_cmd)
				CMD_R, CMD_T: begin
					if (err_q || phase_q == PH_ADDR || count_q == '0) begin
						v_status = ST_BAD;
					end else if (v_cmd == CMD_R && count_q > {16'd0, max_read_count}) begin
						v_status = ST_OVER;
					end
					res.count = count_q;
				end
				CMD_W: begin
					if (err_q) begin
						v_status = ST_BAD;
					end else if (half_q) begin
						v_status = ST_ODD;
					end else begin
						res.count = {22'd0, bytes_q};
					end
				end
				CMD_X: begin
					if (err_q) begin
						v_status = ST_BAD;
					end
				end
				default: begin
					res.address = '0;
				end
			endcase
			res.status = v_status;
			// start the next line from scratch
			pos_d    = '0;
			cmd_d    = CMD_OTHER;
			letter_d = '0;
			phase_d  = PH_ADDR;
			addr_d   = '0;
			count_d  = '0;
			nibble_d = '0;
			half_d   = 1'b0;
			bytes_d  = '0;
			err_d    = 1'b0;
		end else if (pos_q == '0) begin
			letter_d = ch;
			case (ch)
				"r":     cmd_d = CMD_R;
				"t":     cmd_d = CMD_T;
				"w":     cmd_d = CMD_W;
				"x":     cmd_d = CMD_X;
				default: cmd_d = CMD_OTHER;
			endcase
			pos_d = POS_W'(1);
		end else begin
			pos_d = pos_q + POS_W'(1);
			// the character after the letter is skipped
			if (pos_q != POS_W'(1) && !err_q && cmd_q != CMD_OTHER) begin
				case (phase_q)
					PH_ADDR: begin
						if (ch == CH_SPACE) begin
							if (cmd_q == CMD_R || cmd_q == CMD_T) begin
								phase_d = PH_COUNT;
							end else if (cmd_q == CMD_W) begin
								phase_d = PH_DATA;
							end else begin
								phase_d = PH_DONE;
							end
						end else if (hex_ok) begin
							addr_d = {addr_q[59:0], hex_val};
						end else begin
							err_d = 1'b1;
						end
					end
					PH_COUNT: begin
						if (ch == CH_SPACE) begin
							phase_d = PH_DONE;
						end else if (dec_ok) begin
							count_d = (count_q << 3) + (count_q << 1) + {28'd0, hex_val};
						end else begin
							err_d = 1'b1;
						end
					end
					PH_DATA: begin
						if (ch != CH_SPACE) begin
							if (!hex_ok) begin
								err_d = 1'b1;
							end else if (half_q) begin
								produce = 1'b1;
								res.kind = 1'b0;
								res.command = cmd_q;
								res.letter = letter_q;
								res.status = ST_OK;
								res.address = addr_q;
								res.data_byte = {nibble_q, hex_val};
								res.byte_index = bytes_q;
								bytes_d = bytes_q + 10'd1;
								nibble_d = '0;
								half_d = 1'b0;
							end else begin
								nibble_d = hex_val;
								half_d = 1'b1;
							end
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			cmd_q    <= CMD_OTHER;
			letter_q <= '0;
			phase_q  <= PH_ADDR;
			addr_q   <= '0;
			count_q  <= '0;
			nibble_q <= '0;
			half_q   <= 1'b0;
			bytes_q  <= '0;
			err_q    <= 1'b0;
		end else if (step) begin
			pos_q    <= pos_d;
			cmd_q    <= cmd_d;
			letter_q <= letter_d;
			phase_q  <= phase_d;
			addr_q   <= addr_d;
			count_q  <= count_d;
			nibble_q <= nibble_d;
			half_q   <= half_d;
			bytes_q  <= bytes_d;
			err_q    <= err_d;
		end
	end

endmodule

// File: design/monitor_command_line_parser.sv
`timescale 1ns / 1ps
// A character accepted into the input register is parsed from there, and its result, if any, is
// loaded into the result register, from which it is offered on result_out.
// Throughput: one character per cycle; the input register and the parse stage (state update
// plus result register) run overlapped, and a held result stalls input only when both are full.
// Reset (arst_n low, asynchronous): parser returns to the start of a line, both stages empty,
// max_read_count back to 1024.
module monitor_command_line_parser import mclp_pkg::*; #(
	parameter int MAX_LINE = MAX_LINE_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	mclp_char_if.sink             char_in,
	mclp_result_if.source         result_out,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	logic        valid_s1;
	logic [7:0]  ch_s1;
	logic        out_valid_q;
	result_t     res_q;
	logic        advance;
	logic        produce;
	result_t     res;
	logic [15:0] max_read_count;

	mclp_cfg u_cfg (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.max_read_count (max_read_count)
	);

	mclp_parser #(
		.MAX_LINE (MAX_LINE)
	) u_parser (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (valid_s1 && advance),
		.ch             (ch_s1),
		.max_read_count (max_read_count),
		.produce        (produce),
		.res            (res)
	);

	// advance when the result register is empty or being drained
	assign advance = !out_valid_q || result_out.ready;
	assign char_in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (char_in.ready) begin
				valid_s1 <= char_in.valid;
			end
			if (advance) begin
				out_valid_q <= valid_s1 && produce;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (char_in.ready && char_in.valid) begin
			ch_s1 <= char_in.ch;
		end
		if (advance && valid_s1 && produce) begin
			res_q <= res;
		end
	end

	assign result_out.valid      = out_valid_q;
	assign result_out.kind       = res_q.kind;
	assign result_out.command    = res_q.command;
	assign result_out.letter     = res_q.letter;
	assign result_out.status     = res_q.status;
	assign result_out.address    = res_q.address;
	assign result_out.count      = res_q.count;
	assign result_out.data_byte  = res_q.data_byte;
	assign result_out.byte_index = res_q.byte_index;

endmodule
